FILE: src/sbct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared widths, command codes and the queue entry type for the sensor band
// calibration and trigger block.
// ----------------------------------------------------------------------------
package sbct_pkg;

  localparam int WINDOW_SAMPLES = 1048576;
  localparam int SAMPLE_BITS    = 10;

  localparam int CMD_W  = 2;
  localparam int SMP_W  = 10;
  localparam int HI_W   = 11;
  localparam int LO_W   = 16;
  localparam int MEAN_W = 10;
  localparam int SUM_W  = 30;
  localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [SMP_W-1:0] SMP_MASK  = SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] WINDOW_MAX = CNT_W'(WINDOW_SAMPLES);
  localparam logic [HI_W-1:0]  MAX_LIMIT = HI_W'(1118);
  localparam logic [HI_W-1:0]  HI_MARGIN = HI_W'(5);
  localparam logic [LO_W-1:0]  LO_MARGIN = LO_W'(5);
  localparam logic [LO_W-1:0]  LO_RESET  = 16'hFFFF;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_START,
    OP_FINISH,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SMP_W-1:0] sample;
  } item_t;

endpackage

FILE: src/sensor_band_calibrate_and_trigger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_band_calibrate_and_trigger
// Calibrates a sample band from converter readings and flags later samples
// that fall outside it.
// ----------------------------------------------------------------------------
// Each input transaction carries a command (tuser) and a 10-bit sample
// (tdata). Start opens a calibration window and resets the band; samples
// inside the window track max, min, sum and count (count stops at the
// window size); finish widens the band by 5 on each side where the limits
// allow and stores the mean. Outside a window each sample is checked
// against the band and flagged on the output. Every input transaction gives
// exactly one output transaction showing the state after that command. A
// sample, start, unused or idle-finish command is executed without the
// divider, so one transaction per cycle is sustained while the result is
// taken at once. A finish that closes a window with samples runs the serial
// mean divider, one quotient bit per cycle over 30 bits, before its result
// is written. A two-entry queue sits between decode and execution so input
// can keep being taken while the divider runs or the output is stalled.
// ----------------------------------------------------------------------------
module sensor_band_calibrate_and_trigger
  import sbct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [9:0] sample
  input  logic [CMD_W-1:0] s_axis_tuser,   // [1:0] command
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [10:0] upper_bound, [26:11] lower_bound,
                                           // [36:27] mean_level
  output logic [1:0]       m_axis_tuser    // [0] out_of_band, [1] busy_calibrating
);

  // decode -> queue
  item_t push_item;
  logic  q_push;
  logic  q_full;

  // queue -> execution
  item_t pop_item;
  logic  q_pop;
  logic  q_empty;

  sbct_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  sbct_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (push_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (pop_item),
    .empty   (q_empty)
  );

  // execution: band state, trigger test, serial divider, result register
  sbct_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: src/sbct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_front
// Input side: takes command transactions, decodes them into operations and
// pushes them into the queue.
// ----------------------------------------------------------------------------
module sbct_front
  import sbct_pkg::*;
(
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [9:0] sample
  input  logic [CMD_W-1:0] s_axis_tuser,   // [1:0] command
  input  logic             q_full,
  output logic             q_push,
  output item_t            q_item
);

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    q_item.sample = s_axis_tdata[SMP_W-1:0] & SMP_MASK;
    case (s_axis_tuser)
      CMD_SAMPLE: q_item.op = OP_SAMPLE;
      CMD_START:  q_item.op = OP_START;
      CMD_FINISH: q_item.op = OP_FINISH;
      default:    q_item.op = OP_NONE;
    endcase
  end

endmodule

FILE: src/sbct_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_queue
// Two-entry queue between the decoder and the execution side.
// ----------------------------------------------------------------------------
module sbct_queue
  import sbct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

FILE: src/sbct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_back
// Execution side: calibration state, out-of-band test, serial mean divider
// and the result register.
// ----------------------------------------------------------------------------
module sbct_back
  import sbct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WB
  } state_t;

  state_t              state;
  logic [HI_W-1:0]     high_mark;
  logic [LO_W-1:0]     low_mark;
  logic [MEAN_W-1:0]   mean_store;
  logic [SUM_W-1:0]    running_sum;
  logic [CNT_W-1:0]    sample_count;
  logic                in_window;

  logic [SUM_W-1:0]     quo;
  logic [CNT_W:0]       rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [HI_W-1:0]   out_upper;
  logic [LO_W-1:0]   out_lower;
  logic [MEAN_W-1:0] out_mean;
  logic              out_flag;
  logic              out_busy;

  logic [HI_W-1:0]   high_next;
  logic [LO_W-1:0]   low_next;
  logic [MEAN_W-1:0] mean_next;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic              window_next;
  logic              flag_next;
  logic              go_div;

  logic              out_free;
  logic              out_load;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W+1:0]  rem_diff;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign q_pop    = (state == ST_IDLE) && !q_empty && out_free;
  // result register gets a new transaction this cycle
  assign out_load = (q_pop && !go_div) || ((state == ST_WB) && out_free);

  assign m_axis_tdata = {3'b000, out_mean, out_lower, out_upper};
  assign m_axis_tuser = {out_busy, out_flag};

  // restoring divide, one quotient bit per cycle
  assign rem_shift = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, sample_count};

  always_comb begin
    high_next   = high_mark;
    low_next    = low_mark;
    mean_next   = mean_store;
    sum_next    = running_sum;
    count_next  = sample_count;
    window_next = in_window;
    flag_next   = 1'b0;
    go_div      = 1'b0;
    case (q_item.op)
      OP_START: begin
        high_next   = '0;
        low_next    = LO_RESET;
        mean_next   = '0;
        sum_next    = '0;
        count_next  = '0;
        window_next = 1'b1;
      end
      OP_FINISH: begin
        if (in_window) begin
          if (high_mark < MAX_LIMIT) begin
            high_next = high_mark + HI_MARGIN;
          end
          if (low_mark > LO_MARGIN) begin
            low_next = low_mark - LO_MARGIN;
          end
          window_next = 1'b0;
          if (sample_count != '0) begin
            go_div = 1'b1;
          end else begin
            mean_next = '0;
          end
        end
      end
      OP_SAMPLE: begin
        if (in_window) begin
          if (sample_count < WINDOW_MAX) begin
            if (HI_W'(q_item.sample) > high_mark) begin
              high_next = HI_W'(q_item.sample);
            end
            if (LO_W'(q_item.sample) < low_mark) begin
              low_next = LO_W'(q_item.sample);
            end
            sum_next   = running_sum + SUM_W'(q_item.sample);
            count_next = sample_count + CNT_W'(1);
          end
        end else begin
          flag_next = (HI_W'(q_item.sample) > high_mark) ||
                      (LO_W'(q_item.sample) < low_mark);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      high_mark     <= '0;
      low_mark      <= LO_RESET;
      mean_store    <= '0;
      running_sum   <= '0;
      sample_count  <= '0;
      in_window     <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            high_mark    <= high_next;
            low_mark     <= low_next;
            mean_store   <= mean_next;
            running_sum  <= sum_next;
            sample_count <= count_next;
            in_window    <= window_next;
            if (go_div) begin
              quo     <= running_sum;
              rem     <= '0;
              div_cnt <= '0;
              state   <= ST_DIV;
            end else begin
              out_upper     <= high_next;
              out_lower     <= low_next;
              out_mean      <= mean_next;
              out_flag      <= flag_next;
              out_busy      <= window_next;
            end
          end
        end
        ST_DIV: begin
          if (rem_diff[CNT_W+1]) begin
            rem <= rem_shift;
            quo <= {quo[SUM_W-2:0], 1'b0};
          end else begin
            rem <= rem_diff[CNT_W:0];
            quo <= {quo[SUM_W-2:0], 1'b1};
          end
          if (div_cnt == DIV_CNT_W'(SUM_W - 1)) begin
            state <= ST_WB;
          end else begin
            div_cnt <= div_cnt + DIV_CNT_W'(1);
          end
        end
        ST_WB: begin
          if (out_free) begin
            mean_store    <= quo[MEAN_W-1:0];
            out_upper     <= high_mark;
            out_lower     <= low_mark;
            out_mean      <= quo[MEAN_W-1:0];
            out_flag      <= 1'b0;
            out_busy      <= in_window;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
